/* src/ffpt_pkg.sv */
// ----------------------------------------------------------------------------
// ffpt_pkg
// Shared widths, register indexes and types of the fast filter trigger.
// ----------------------------------------------------------------------------
package ffpt_pkg;

   // Default build values
   localparam int FILTER_LEN_DEF   = 16;
   localparam int MAX_WAVE_LEN_DEF = 65536;

   // Fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int POS_W    = 16;
   localparam int FILT_W   = 17;
   localparam int BASE_W   = 12;
   localparam int GAIN_W   = 16;
   localparam int THR_W    = 25;

   // Gain is unsigned Q8.8
   localparam int GAIN_FRAC = 8;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

   // Register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_COUNT     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_GAIN = 1'd1;

   // Bookkeeping that rides along with a sum through the divider
   typedef struct packed {
      logic [POS_W-1:0] pos;   // position this word refers to
      logic [POS_W-1:0] idx;   // index of the sample that produced it
      logic             last;  // sample closed the waveform
      logic             ok;    // full window on both sides
   } ffpt_tag_type;

endpackage

/* src/ffpt_if.sv */
// ----------------------------------------------------------------------------
// ffpt_if
// Valid/ready channels for samples in and trigger results out.
// ----------------------------------------------------------------------------
interface ffpt_req_if;
   logic                          valid;
   logic                          ready;
   logic [ffpt_pkg::SAMPLE_W-1:0] sample;
   logic                          last;

   modport source (output valid, sample, last, input ready);
   modport sink   (input valid, sample, last, output ready);
endinterface

interface ffpt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ffpt_pkg::POS_W-1:0]         position;
   logic signed [ffpt_pkg::FILT_W-1:0] filter_value;
   logic                               trigger;
   logic                               end_of_run;

   modport source (output valid, position, filter_value, trigger, end_of_run, input ready);
   modport sink   (input valid, position, filter_value, trigger, end_of_run, output ready);
endinterface

/* src/ffpt_div.sv */
// ----------------------------------------------------------------------------
// ffpt_div
// Three-stage divide of a signed window sum by FILTER_LEN, toward zero.
// Reciprocal multiply in two partial products, then one correction step.
// ----------------------------------------------------------------------------
module ffpt_div #(
   parameter int FILTER_LEN = ffpt_pkg::FILTER_LEN_DEF
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   en,
   input  logic                                                   in_valid,
   input  logic signed [ffpt_pkg::SAMPLE_W+$clog2(FILTER_LEN):0] in_sum,
   input  ffpt_pkg::ffpt_tag_type                                 in_tag,
   output logic                                                   out_valid,
   output logic signed [ffpt_pkg::FILT_W-1:0]                     out_filter,
   output ffpt_pkg::ffpt_tag_type                                 out_tag
);
   import ffpt_pkg::*;

   localparam int NW = SAMPLE_W + $clog2(FILTER_LEN);   // magnitude bits
   localparam int HW = (NW + 1) / 2;                     // low partial width
   localparam int UW = NW - HW;                          // high partial width
   localparam int PW = 2 * NW + 1;                       // full product width
   localparam int QW = FILT_W - 1;                       // quotient bits
   localparam longint unsigned RECIP_L = (64'd1 << NW) / FILTER_LEN;
   localparam logic [NW:0] RECIP = (NW+1)'(RECIP_L);

   // stage a: magnitude and partial products
   logic              a_valid_ff;
   ffpt_tag_type      a_tag_ff;
   logic              a_neg_ff;
   logic [NW-1:0]     a_mag_ff;
   logic [HW+NW:0]    a_pp_lo_ff;
   logic [UW+NW:0]    a_pp_hi_ff;
   // stage b: estimated quotient
   logic              b_valid_ff;
   ffpt_tag_type      b_tag_ff;
   logic              b_neg_ff;
   logic [NW-1:0]     b_mag_ff;
   logic [QW-1:0]     b_q0_ff;
   // stage c: corrected, signed result
   logic              c_valid_ff;
   ffpt_tag_type      c_tag_ff;
   logic signed [FILT_W-1:0] c_filter_ff;

   logic [NW:0]       mag_wide;
   logic [NW-1:0]     mag_in;
   logic [PW-1:0]     prod_sum;
   logic [NW-1:0]     back_prod;
   logic [NW-1:0]     rem;
   logic [QW:0]       quot;
   logic signed [FILT_W-1:0] filter_in;

   // take the magnitude; it always fits NW bits
   always_comb begin
      mag_wide = in_sum[NW] ? (NW+1)'(-in_sum) : (NW+1)'(in_sum);
      mag_in   = mag_wide[NW-1:0];
   end

   // recombine partial products and drop the fraction
   always_comb begin
      prod_sum = PW'({a_pp_hi_ff, {HW{1'b0}}}) + PW'(a_pp_lo_ff);
   end

   // fix the estimate, which is low by at most one
   always_comb begin
      back_prod = NW'(32'(b_q0_ff) * FILTER_LEN);
      rem       = b_mag_ff - back_prod;
      quot      = (rem >= NW'(FILTER_LEN)) ? ((QW+1)'(b_q0_ff) + 1'b1) : (QW+1)'(b_q0_ff);
      if (!b_tag_ff.ok) begin
         filter_in = '0;
      end else if (b_neg_ff) begin
         filter_in = -$signed(quot);
      end else begin
         filter_in = $signed(quot);
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         a_tag_ff    <= in_tag;
         a_neg_ff    <= in_sum[NW];
         a_mag_ff    <= mag_in;
         a_pp_lo_ff  <= (HW+NW+1)'(mag_in[HW-1:0]) * (HW+NW+1)'(RECIP);
         a_pp_hi_ff  <= (UW+NW+1)'(mag_in[NW-1:HW]) * (UW+NW+1)'(RECIP);
         b_tag_ff    <= a_tag_ff;
         b_neg_ff    <= a_neg_ff;
         b_mag_ff    <= a_mag_ff;
         b_q0_ff     <= prod_sum[NW +: QW];
         c_tag_ff    <= b_tag_ff;
         c_filter_ff <= filter_in;
      end
   end

   assign out_valid  = c_valid_ff;
   assign out_filter = c_filter_ff;
   assign out_tag    = c_tag_ff;

endmodule

/* src/fast_filter_pulse_trigger_unit.sv */
// ----------------------------------------------------------------------------
// fast_filter_pulse_trigger_unit
// Fast filter, learned noise threshold and leading-edge trigger per waveform.
// ----------------------------------------------------------------------------
// Takes one waveform sample per clock while the result side takes words and
// no tail is draining, and returns one result word per position, FILTER_LEN-1
// samples after that position's own sample. The filter is kept as a running
// sum updated from a history RAM of 2*FILTER_LEN samples, read at two
// addresses whenever the pipe advances. The last sample of a waveform
// releases every position still open; the input is held off while that tail
// drains, one word per cycle while the result side takes words, after which
// the block starts the next waveform. Write base_count and threshold_gain only
// between waveforms.
module fast_filter_pulse_trigger_unit #(
   parameter int FILTER_LEN   = ffpt_pkg::FILTER_LEN_DEF,
   parameter int MAX_WAVE_LEN = ffpt_pkg::MAX_WAVE_LEN_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   ffpt_req_if.sink                           req_bus,
   ffpt_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [ffpt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ffpt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ffpt_pkg::*;

   localparam int CW  = $clog2(MAX_WAVE_LEN);          // sample counter bits
   localparam int HD  = 2 * FILTER_LEN;                // history depth
   localparam int HAW = $clog2(HD);                    // history address bits
   localparam int NW  = SAMPLE_W + $clog2(FILTER_LEN); // window sum magnitude bits

   // configuration
   logic [BASE_W-1:0] base_ff;
   logic [GAIN_W-1:0] gain_ff;

   // front end
   logic [CW-1:0]       cnt_ff;
   logic [HAW-1:0]      wp_ff;
   logic [HAW:0]        wp_ext;
   logic [HAW-1:0]      mid_addr;
   logic                accept;
   logic                last_eff;
   logic                adv;
   logic [SAMPLE_W-1:0] hist_mem [HD];
   logic [SAMPLE_W-1:0] rd_old_ff;
   logic [SAMPLE_W-1:0] rd_mid_ff;

   // stage 0
   logic                s0_valid_ff;
   logic [SAMPLE_W-1:0] s0_sample_ff;
   logic [CW-1:0]       s0_idx_ff;
   logic                s0_last_ff;
   logic                s0_has_mid_ff;
   logic                s0_has_old_ff;

   // running sum
   logic signed [NW:0]   acc_ff;
   logic signed [NW+2:0] acc_wide;
   logic signed [NW:0]   acc_in;
   logic [SAMPLE_W-1:0]  mid_val;
   logic [SAMPLE_W-1:0]  old_val;
   logic                 emit_norm;
   logic                 div_in_valid;
   ffpt_tag_type         div_in_tag;

   // divider output
   logic                     d_valid;
   logic signed [FILT_W-1:0] d_filter;
   ffpt_tag_type             d_tag;

   // result stage
   logic                     flush_ff;
   logic [POS_W-1:0]         fl_pos_ff;
   logic [POS_W-1:0]         fl_end_ff;
   logic [THR_W-1:0]         thr_ff;
   logic [THR_W-1:0]         thr_in;
   logic signed [FILT_W-1:0] prev_ff;
   logic signed [FILT_W-1:0] older_ff;
   logic                     out_free;
   logic                     fire;
   logic [POS_W-1:0]         c_pos;
   logic signed [FILT_W-1:0] c_f;
   logic                     c_end;
   logic                     c_trig;
   logic                     start_flush;
   logic signed [THR_W:0]    f_ext;
   logic signed [THR_W:0]    prev_ext;
   logic signed [THR_W:0]    older_ext;
   logic signed [THR_W:0]    thr_ext;
   logic [THR_W+GAIN_W-1:0]  scaled;

   logic                     rsp_valid_ff;
   logic [POS_W-1:0]         rsp_pos_ff;
   logic signed [FILT_W-1:0] rsp_filter_ff;
   logic                     rsp_trig_ff;
   logic                     rsp_end_ff;

   // capture register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         gain_ff <= GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_COUNT:     base_ff <= csr_wdata[BASE_W-1:0];
            CSR_THRESHOLD_GAIN: gain_ff <= csr_wdata[GAIN_W-1:0];
            default:            ;
         endcase
      end
   end

   // handshake: front end and divider advance together
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign adv           = out_free && !flush_ff;
   assign req_bus.ready = adv;
   assign accept        = req_bus.valid && adv;
   assign last_eff      = req_bus.last || (cnt_ff == CW'(MAX_WAVE_LEN - 1));

   // address of the sample FILTER_LEN back
   always_comb begin
      wp_ext   = {1'b0, wp_ff};
      mid_addr = (wp_ext >= (HAW+1)'(FILTER_LEN)) ? HAW'(wp_ext - (HAW+1)'(FILTER_LEN))
                                                  : HAW'(wp_ext + (HAW+1)'(FILTER_LEN));
   end

   // advance sample counter and write pointer; restart on the last sample
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= '0;
      end else if (accept) begin
         if (last_eff) begin
            cnt_ff <= '0;
            wp_ff  <= '0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
            wp_ff  <= (wp_ff == HAW'(HD - 1)) ? '0 : wp_ff + 1'b1;
         end
      end
   end

   // history RAM: read the slot being replaced and the middle tap
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_old_ff <= hist_mem[wp_ff];
         rd_mid_ff <= hist_mem[mid_addr];
         if (req_bus.valid) begin
            hist_mem[wp_ff] <= req_bus.sample;
         end
      end
   end

   // stage 0 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_sample_ff  <= req_bus.sample;
         s0_idx_ff     <= cnt_ff;
         s0_last_ff    <= last_eff;
         s0_has_mid_ff <= 32'(cnt_ff) >= 32'(FILTER_LEN);
         s0_has_old_ff <= 32'(cnt_ff) >= 32'(HD);
      end
   end

   // update the running difference of the two windows
   always_comb begin
      mid_val  = s0_has_mid_ff ? rd_mid_ff : '0;
      old_val  = s0_has_old_ff ? rd_old_ff : '0;
      acc_wide = (NW+3)'(acc_ff)
               + $signed((NW+3)'(s0_sample_ff))
               - $signed((NW+3)'({mid_val, 1'b0}))
               + $signed((NW+3)'(old_val));
      acc_in   = acc_wide[NW:0];

      emit_norm       = 32'(s0_idx_ff) >= 32'(FILTER_LEN - 1);
      div_in_valid    = s0_valid_ff && (emit_norm || s0_last_ff);
      div_in_tag.pos  = emit_norm ? POS_W'(s0_idx_ff - CW'(FILTER_LEN - 1)) : '0;
      div_in_tag.idx  = POS_W'(s0_idx_ff);
      div_in_tag.last = s0_last_ff;
      div_in_tag.ok   = 32'(s0_idx_ff) >= 32'(HD - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (adv && s0_valid_ff) begin
         acc_ff <= s0_last_ff ? '0 : acc_in;
      end
   end

   ffpt_div #(
      .FILTER_LEN (FILTER_LEN)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (div_in_valid),
      .in_sum     (acc_in),
      .in_tag     (div_in_tag),
      .out_valid  (d_valid),
      .out_filter (d_filter),
      .out_tag    (d_tag)
   );

   // pick the next result word: pipeline word or zero-filter tail
   always_comb begin
      if (flush_ff) begin
         c_pos = fl_pos_ff;
         c_f   = '0;
         c_end = fl_pos_ff == fl_end_ff;
      end else begin
         c_pos = d_tag.pos;
         c_f   = d_filter;
         c_end = d_tag.last && (d_tag.pos == d_tag.idx);
      end
      fire        = out_free && (flush_ff || d_valid);
      start_flush = !flush_ff && d_valid && d_tag.last && !c_end;
   end

   // learn, scale and test against the threshold
   always_comb begin
      f_ext     = (THR_W+1)'(c_f);
      prev_ext  = (THR_W+1)'(prev_ff);
      older_ext = (THR_W+1)'(older_ff);
      thr_ext   = $signed({1'b0, thr_ff});
      scaled    = thr_ff * gain_ff;
      thr_in    = thr_ff;
      c_trig    = 1'b0;
      priority if (c_pos < POS_W'(base_ff)) begin
         if (f_ext > thr_ext) begin
            thr_in = f_ext[THR_W-1:0];
         end
      end else if (c_pos == POS_W'(base_ff)) begin
         thr_in = scaled[GAIN_FRAC +: THR_W];
      end else begin
         c_trig = (f_ext >= thr_ext) && (prev_ext < thr_ext) && (older_ext < thr_ext);
      end
   end

   // hold threshold history; clear it after the final word
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= '0;
         prev_ff  <= '0;
         older_ff <= '0;
      end else if (fire) begin
         if (c_end) begin
            thr_ff   <= '0;
            prev_ff  <= '0;
            older_ff <= '0;
         end else begin
            thr_ff   <= thr_in;
            prev_ff  <= c_f;
            older_ff <= prev_ff;
         end
      end
   end

   // drain the tail positions after the last sample
   always_ff @(posedge clock) begin
      if (reset) begin
         flush_ff <= 1'b0;
      end else if (fire) begin
         if (start_flush) begin
            flush_ff <= 1'b1;
         end else if (flush_ff && c_end) begin
            flush_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         if (start_flush) begin
            fl_pos_ff <= d_tag.pos + 1'b1;
            fl_end_ff <= d_tag.idx;
         end else begin
            fl_pos_ff <= fl_pos_ff + 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_pos_ff    <= c_pos;
         rsp_filter_ff <= c_f;
         rsp_trig_ff   <= c_trig;
         rsp_end_ff    <= c_end;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.position     = rsp_pos_ff;
   assign rsp_bus.filter_value = rsp_filter_ff;
   assign rsp_bus.trigger      = rsp_trig_ff;
   assign rsp_bus.end_of_run   = rsp_end_ff;

endmodule
